### hw/rtl/dlpe_pkg.sv
// Shared types and constants of the DWARF line-program encoder.
package dlpe_pkg;

	// Standard opcodes and end-of-sequence bytes
	localparam logic [7:0] OP_COPY         = 8'h01;
	localparam logic [7:0] OP_ADVANCE_PC   = 8'h02;
	localparam logic [7:0] OP_ADVANCE_LINE = 8'h03;
	localparam logic [7:0] OP_EXT_ESC      = 8'h00;
	localparam logic [7:0] OP_EXT_LEN      = 8'h01;
	localparam logic [7:0] OP_END_SEQ      = 8'h01;

	// Input actions
	localparam logic ACT_ROW    = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LBASE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LRANGE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPCODE_BASE = 2'd2;

	// Register reset values
	localparam logic [7:0] LBASE_RST       = 8'hFB;	// -5
	localparam logic [7:0] LRANGE_RST      = 8'd14;
	localparam logic [7:0] OPCODE_BASE_RST = 8'd13;

	// LEB128 shifter: five 7-bit digits hold a 33-bit signed value
	localparam int unsigned DIGIT_W = 7;
	localparam int unsigned LEB_W   = 35;

	localparam logic [16:0] SPECIAL_MAX = 17'd255;

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_CHK1 = 11'b000_0000_0010,
		S_CHK2 = 11'b000_0000_0100,
		S_OPA  = 11'b000_0000_1000,
		S_LEBA = 11'b000_0001_0000,
		S_OPB  = 11'b000_0010_0000,
		S_LEBB = 11'b000_0100_0000,
		S_T0   = 11'b000_1000_0000,
		S_T1   = 11'b001_0000_0000,
		S_T2   = 11'b010_0000_0000,
		S_SPEC = 11'b100_0000_0000
	} state_t;

endpackage

### hw/rtl/dwarf_line_program_encoder_unit.sv
// Top level of the DWARF line-number program encoder.
//
// channel | role   | signals                                     | beat when
// --------+--------+---------------------------------------------+--------------------
// in      | sink   | in_valid in_stall action src_line           | in_valid & !in_stall
//         |        | code_offset                                 |
// out     | source | out_valid out_stall out_byte last_of_run    | out_valid & !out_stall
// cfg     | sink   | cfg_valid cfg_ready cfg_index cfg_data      | cfg_valid & cfg_ready
//
// Items: one item at a time; an item gives N (1..13) bytes. One byte leaves per
// cycle while out_stall is low; LEB128 values go out of a 35-bit shifter one 7-bit
// digit per cycle. A later row first passes the special-opcode check (line window
// and 8x8 multiply in S_CHK1, then the sum in S_CHK2).
// Reset: arst_n clears state, registers to defaults, empty output register.
// Stalls: out_stall freezes the byte sequencer; the next item is taken while the
// final byte of the previous one still waits in the output register.
module dwarf_line_program_encoder_unit #(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// item input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [31:0] src_line,
	input  logic [31:0] code_offset,
	// byte output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [dlpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]  cfg_data
);

	// pc deltas wrap at the smaller of OFFSET_BITS and the 32-bit offset width
	localparam int unsigned PC_BITS = (OFFSET_BITS > 32) ? 32 : OFFSET_BITS;
	localparam logic [31:0] PC_MASK = 32'hFFFF_FFFF >> (32 - PC_BITS);
	localparam int unsigned LW = dlpe_pkg::LEB_W;
	localparam int unsigned DW = dlpe_pkg::DIGIT_W;

	// control and sequence state
	dlpe_pkg::state_t state_q, state_d;
	logic        out_valid_q;
	logic [7:0]  lbase_q, lrange_q, opcode_base_q;
	logic [31:0] cur_line_q, prev_off_q;
	logic        first_row_q;

	// per-item payload
	logic [7:0]    opa_q, opb_q, spec_q;
	logic [LW-1:0] leb_a_q, leb_b_q;
	logic          sgn_a_q, sgn_b_q, en_b_q, tail_end_q;
	logic          inrange_q, small_q;
	logic [7:0]    dlb8_q;
	logic [15:0]   prod_q;
	logic [7:0]    out_byte_q;
	logic          last_q;

	logic        in_acc, cfg_acc, go, emit;
	logic [32:0] dline_w;
	logic [31:0] dpc_w;
	logic [LW-1:0] dline_x, dpc_x;
	logic [LW-1:0] dlb_w;
	logic [16:0] sum_w;
	logic        fits_w;
	logic [LW-1:0] cur_leb, rest_w;
	logic        cur_sgn, leb_done;
	logic [DW-1:0] digit_w;
	logic [7:0]  byte_d;
	logic        last_d;

	assign in_stall  = (state_q != dlpe_pkg::S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign go        = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	// deltas against the kept state; a pending first row sees line 1 and offset 0
	assign dline_w = {1'b0, src_line} - {1'b0, cur_line_q};
	assign dpc_w   = (code_offset - prev_off_q) & PC_MASK;
	assign dline_x = {{(LW-33){dline_w[32]}}, dline_w};
	assign dpc_x   = {{(LW-32){1'b0}}, dpc_w};

	// special-opcode check, first step: line window against the config
	assign dlb_w = leb_b_q - {{(LW-8){lbase_q[7]}}, lbase_q};
	// second step: opcode sum
	assign sum_w  = {9'd0, dlb8_q} + {1'b0, prod_q} + {9'd0, opcode_base_q};
	assign fits_w = inrange_q && small_q && (sum_w <= dlpe_pkg::SPECIAL_MAX);

	// LEB128 digit out of whichever shifter is active
	assign cur_leb = (state_q == dlpe_pkg::S_LEBB) ? leb_b_q : leb_a_q;
	assign cur_sgn = (state_q == dlpe_pkg::S_LEBB) ? sgn_b_q : sgn_a_q;
	assign digit_w = cur_leb[DW-1:0];
	assign rest_w  = LW'($signed(cur_leb) >>> DW);
	always_comb begin
		if (cur_sgn) begin
			leb_done = ((rest_w == '0) && !digit_w[DW-1]) ||
				((rest_w == '1) && digit_w[DW-1]);
		end else begin
			leb_done = (rest_w == '0);
		end
	end

	// byte sequencer
	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		byte_d  = dlpe_pkg::OP_COPY;
		last_d  = 1'b0;
		case (state_q)
			dlpe_pkg::S_IDLE: begin
				// first row skips the advances that have nothing to move
				if (in_acc) begin
					if (action == dlpe_pkg::ACT_FINISH) state_d = dlpe_pkg::S_OPA;
					else if (!first_row_q) state_d = dlpe_pkg::S_CHK1;
					else if (src_line != 32'd1) state_d = dlpe_pkg::S_OPA;
					else if (code_offset != 32'd0) state_d = dlpe_pkg::S_OPB;
					else state_d = dlpe_pkg::S_T2;
				end
			end
			dlpe_pkg::S_CHK1: begin
				state_d = dlpe_pkg::S_CHK2;
			end
			dlpe_pkg::S_CHK2: begin
				state_d = fits_w ? dlpe_pkg::S_SPEC : dlpe_pkg::S_OPA;
			end
			dlpe_pkg::S_OPA: begin
				emit   = 1'b1;
				byte_d = opa_q;
				if (go) state_d = dlpe_pkg::S_LEBA;
			end
			dlpe_pkg::S_LEBA: begin
				emit   = 1'b1;
				byte_d = {!leb_done, digit_w};
				if (go && leb_done) begin
					if (en_b_q) state_d = dlpe_pkg::S_OPB;
					else state_d = tail_end_q ? dlpe_pkg::S_T0 : dlpe_pkg::S_T2;
				end
			end
			dlpe_pkg::S_OPB: begin
				emit   = 1'b1;
				byte_d = opb_q;
				if (go) state_d = dlpe_pkg::S_LEBB;
			end
			dlpe_pkg::S_LEBB: begin
				emit   = 1'b1;
				byte_d = {!leb_done, digit_w};
				if (go && leb_done) state_d = tail_end_q ? dlpe_pkg::S_T0 : dlpe_pkg::S_T2;
			end
			dlpe_pkg::S_T0: begin
				emit   = 1'b1;
				byte_d = dlpe_pkg::OP_EXT_ESC;
				if (go) state_d = dlpe_pkg::S_T1;
			end
			dlpe_pkg::S_T1: begin
				emit   = 1'b1;
				byte_d = dlpe_pkg::OP_EXT_LEN;
				if (go) state_d = dlpe_pkg::S_T2;
			end
			dlpe_pkg::S_T2: begin
				// copy and end_sequence share this final byte value
				emit   = 1'b1;
				byte_d = tail_end_q ? dlpe_pkg::OP_END_SEQ : dlpe_pkg::OP_COPY;
				last_d = 1'b1;
				if (go) state_d = dlpe_pkg::S_IDLE;
			end
			dlpe_pkg::S_SPEC: begin
				emit   = 1'b1;
				byte_d = spec_q;
				last_d = 1'b1;
				if (go) state_d = dlpe_pkg::S_IDLE;
			end
			default: begin
				state_d = dlpe_pkg::S_IDLE;
			end
		endcase
	end

	// control, line state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= dlpe_pkg::S_IDLE;
			out_valid_q   <= 1'b0;
			lbase_q       <= dlpe_pkg::LBASE_RST;
			lrange_q      <= dlpe_pkg::LRANGE_RST;
			opcode_base_q <= dlpe_pkg::OPCODE_BASE_RST;
			cur_line_q    <= 32'd1;
			prev_off_q    <= 32'd0;
			first_row_q   <= 1'b1;
		end else begin
			state_q <= state_d;
			if (go) out_valid_q <= emit;
			if (cfg_acc) begin
				case (cfg_index)
					dlpe_pkg::REG_LBASE:       lbase_q       <= cfg_data;
					dlpe_pkg::REG_LRANGE:      lrange_q      <= cfg_data;
					dlpe_pkg::REG_OPCODE_BASE: opcode_base_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (in_acc) begin
				if (action == dlpe_pkg::ACT_FINISH) begin
					cur_line_q  <= 32'd1;
					prev_off_q  <= 32'd0;
					first_row_q <= 1'b1;
				end else begin
					cur_line_q  <= src_line;
					prev_off_q  <= code_offset;
					first_row_q <= 1'b0;
				end
			end
		end
	end

	// per-item payload and output register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (action == dlpe_pkg::ACT_FINISH) begin
				opa_q      <= dlpe_pkg::OP_ADVANCE_PC;
				leb_a_q    <= dpc_x;
				sgn_a_q    <= 1'b0;
				en_b_q     <= 1'b0;
				tail_end_q <= 1'b1;
			end else if (first_row_q) begin
				// line first, then pc
				opa_q      <= dlpe_pkg::OP_ADVANCE_LINE;
				leb_a_q    <= dline_x;
				sgn_a_q    <= 1'b1;
				opb_q      <= dlpe_pkg::OP_ADVANCE_PC;
				leb_b_q    <= dpc_x;
				sgn_b_q    <= 1'b0;
				en_b_q     <= (code_offset != 32'd0);
				tail_end_q <= 1'b0;
			end else begin
				// long form: pc first, then line
				opa_q      <= dlpe_pkg::OP_ADVANCE_PC;
				leb_a_q    <= dpc_x;
				sgn_a_q    <= 1'b0;
				opb_q      <= dlpe_pkg::OP_ADVANCE_LINE;
				leb_b_q    <= dline_x;
				sgn_b_q    <= 1'b1;
				en_b_q     <= 1'b1;
				tail_end_q <= 1'b0;
			end
		end
		if (state_q == dlpe_pkg::S_CHK1) begin
			inrange_q <= !dlb_w[LW-1] && (dlb_w[LW-1:8] == '0) && (dlb_w[7:0] < lrange_q);
			dlb8_q    <= dlb_w[7:0];
			prod_q    <= {8'd0, lrange_q} * {8'd0, leb_a_q[7:0]};
			small_q   <= (leb_a_q[LW-1:8] == '0);
		end
		if (state_q == dlpe_pkg::S_CHK2) spec_q <= sum_w[7:0];
		if (go) begin
			if (state_q == dlpe_pkg::S_LEBA) leb_a_q <= rest_w;
			if (state_q == dlpe_pkg::S_LEBB) leb_b_q <= rest_w;
			if (emit) begin
				out_byte_q <= byte_d;
				last_q     <= last_d;
			end
		end
	end

	// a new item only starts once every byte but the last has left
	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && out_valid) |-> last_of_run)
		else $error("item accepted with a non-final byte pending");

	// first-row encoding relies on the delta base being line 1, offset 0
	a_first_base: assert property (@(posedge clk) disable iff (!arst_n)
		first_row_q |-> (cur_line_q == 32'd1) && (prev_off_q == 32'd0))
		else $error("pending first row with stale line state");

	// special check resolves to a single opcode or the long form
	a_chk_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dlpe_pkg::S_CHK2) |=>
		(state_q == dlpe_pkg::S_SPEC) || (state_q == dlpe_pkg::S_OPA))
		else $error("bad exit from special-opcode check");

endmodule

### test/dwarf_line_program_encoder_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the DWARF line-number program encoder, with its own byte predictor.
module dwarf_line_program_encoder_unit_tb;

	// Register index that the block has no register for: the write must be dropped.
	localparam logic [dlpe_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// Cycles to let pass after the last byte before a register write or the end.
	localparam int IDLE_PAD = 16;
	localparam int DRAIN_LIMIT = 4000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = dlpe_pkg::ACT_ROW;
	logic [31:0] src_line = '0;
	logic [31:0] code_offset = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [dlpe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	dwarf_line_program_encoder_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.src_line    (src_line),
		.code_offset (code_offset),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the block hangs: far beyond the slowest legal run.
	initial begin
		#6000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shadow of the encoder: registers and sequence state
	// ------------------------------------------------------------------
	logic [7:0]  sh_lbase       = dlpe_pkg::LBASE_RST;
	logic [7:0]  sh_lrange      = dlpe_pkg::LRANGE_RST;
	logic [7:0]  sh_opcode_base = dlpe_pkg::OPCODE_BASE_RST;
	logic [31:0] prog_line      = 32'd1;
	logic [31:0] prog_offset    = 32'd0;
	bit          need_first_row = 1'b1;

	// One expected output beat
	typedef struct packed {
		logic [7:0] value;
		logic       is_last;
	} prog_byte_t;

	prog_byte_t expected_bytes [$];	// bytes still owed by the block, oldest first
	logic [7:0] run_bytes [$];	// bytes of the item being encoded

	int err_count = 0;
	bit no_idle = 1'b0;

	task automatic flag_error(input string msg);
		err_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic void emit_uleb(longint unsigned v);
		logic [7:0] b;
		do begin
			b = {1'b0, v[6:0]};
			v = v >> 7;
			if (v != 0)
				b[7] = 1'b1;
			run_bytes.push_back(b);
		end while (v != 0);
	endfunction

	function automatic void emit_sleb(longint v);
		logic [7:0] b;
		bit done;
		done = 1'b0;
		while (!done) begin
			b = {1'b0, v[6:0]};
			v = v >>> 7;
			// stop once the rest is pure sign and bit 6 agrees with it
			if ((v == 0 && !b[6]) || (v == -1 && b[6]))
				done = 1'b1;
			else
				b[7] = 1'b1;
			run_bytes.push_back(b);
		end
	endfunction

	// Bytes of one item into run_bytes; advances the shadow state.
	function automatic void encode_item(logic act, logic [31:0] line, logic [31:0] offs);
		longint dline, lb, lmax;
		longint unsigned dpc, opc;
		logic [31:0] delta32;
		bit fits;
		run_bytes.delete();
		delta32 = offs - prog_offset;	// pc step wraps at 32 bits
		dpc = {32'd0, delta32};
		if (act == dlpe_pkg::ACT_FINISH) begin
			run_bytes.push_back(dlpe_pkg::OP_ADVANCE_PC);
			emit_uleb(dpc);
			run_bytes.push_back(dlpe_pkg::OP_EXT_ESC);
			run_bytes.push_back(dlpe_pkg::OP_EXT_LEN);
			run_bytes.push_back(dlpe_pkg::OP_END_SEQ);
			prog_line = 32'd1;
			prog_offset = 32'd0;
			need_first_row = 1'b1;
		end else if (need_first_row) begin
			if (line != 32'd1) begin
				run_bytes.push_back(dlpe_pkg::OP_ADVANCE_LINE);
				emit_sleb(longint'({32'd0, line}) - 1);
			end
			if (offs != 32'd0) begin
				run_bytes.push_back(dlpe_pkg::OP_ADVANCE_PC);
				emit_uleb({32'd0, offs});
			end
			run_bytes.push_back(dlpe_pkg::OP_COPY);
			prog_line = line;
			prog_offset = offs;
			need_first_row = 1'b0;
		end else begin
			dline = longint'({32'd0, line}) - longint'({32'd0, prog_line});
			lb = longint'($signed(sh_lbase));
			lmax = lb + longint'({56'd0, sh_lrange}) - 1;
			fits = 1'b0;
			if (dline >= lb && dline <= lmax) begin
				opc = dline - lb;
				opc = opc + {56'd0, sh_lrange} * dpc + {56'd0, sh_opcode_base};
				fits = (opc <= 255);
			end
			if (fits) begin
				run_bytes.push_back(opc[7:0]);
			end else begin
				run_bytes.push_back(dlpe_pkg::OP_ADVANCE_PC);
				emit_uleb(dpc);
				run_bytes.push_back(dlpe_pkg::OP_ADVANCE_LINE);
				emit_sleb(dline);
				run_bytes.push_back(dlpe_pkg::OP_COPY);
			end
			prog_line = line;
			prog_offset = offs;
		end
	endfunction

	// ------------------------------------------------------------------
	// Drivers. Every task starts and ends at a falling edge; valid is
	// left as it is on return so a back-to-back beat never sees a
	// lower-then-raise within one step.
	// ------------------------------------------------------------------
	task automatic send_item(input logic act, input logic [31:0] line, input logic [31:0] offs,
			input logic [3:0] n_typed, input logic [103:0] typed);
		prog_byte_t pb;
		int k;
		while (!no_idle && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		src_line    <= line;
		code_offset <= offs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// beat taken: predict, or use the bytes typed into the table
		encode_item(act, line, offs);
		if (n_typed != 0) begin
			run_bytes.delete();
			for (k = 0; k < n_typed; k++)
				run_bytes.push_back(typed[(n_typed - 1 - k) * 8 +: 8]);
		end
		for (k = 0; k < run_bytes.size(); k++) begin
			pb.value = run_bytes[k];
			pb.is_last = (k == run_bytes.size() - 1);
			expected_bytes.push_back(pb);
		end
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [dlpe_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			dlpe_pkg::REG_LBASE:       sh_lbase = val;
			dlpe_pkg::REG_LRANGE:      sh_lrange = val;
			dlpe_pkg::REG_OPCODE_BASE: sh_opcode_base = val;
			default: ;	// no such register: dropped
		endcase
		@(negedge clk);
	endtask

	// Stop sending and wait until every owed byte is out, then let the block settle.
	task automatic drain_program();
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		repeat (IDLE_PAD) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Output side: random stalls, byte checker
	// ------------------------------------------------------------------
	always @(negedge clk)
		out_stall <= !no_idle && ($urandom_range(99) < 31);

	prog_byte_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				flag_error($sformatf("byte %02h with none expected", out_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.value)
					flag_error($sformatf("out_byte %02h, expected %02h", out_byte, want.value));
				if (last_of_run !== want.is_last)
					flag_error($sformatf("last_of_run %0b, expected %0b on byte %02h",
						last_of_run, want.is_last, want.value));
			end
		end
	end

	// ------------------------------------------------------------------
	// Directed table: register writes and items. n_typed != 0 means the
	// bytes are typed in (first byte in the top of the field); otherwise
	// the predictor supplies them.
	// ------------------------------------------------------------------
	typedef struct packed {
		logic                           is_cfg;
		logic [dlpe_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [7:0]                     reg_val;
		logic                           act;
		logic [31:0]                    line;
		logic [31:0]                    offs;
		logic [3:0]                     n_typed;
		logic [103:0]                   typed;
	} step_row_t;

	step_row_t dir_rows [$];

	function automatic void add_item(logic act, logic [31:0] line, logic [31:0] offs,
			logic [3:0] n, logic [103:0] bytes);
		step_row_t r;
		r = '0;
		r.act = act;
		r.line = line;
		r.offs = offs;
		r.n_typed = n;
		r.typed = bytes;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_write(logic [dlpe_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
		step_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		dir_rows.push_back(r);
	endfunction

	int n_random, n_rows, row_i, r, wait_cnt;
	bit in_cfg;
	logic [31:0] gen_line, gen_offs;
	logic [7:0] gen_val;

	initial begin
		// reset defaults: -5 / 14 / 13
		add_item(dlpe_pkg::ACT_FINISH, 32'd0, 32'd0, 4'd5, 104'h02_00_00_01_01);	// no rows
		add_item(dlpe_pkg::ACT_ROW, 32'd1, 32'd0, 4'd1, 104'h01);	// first row, no advance
		add_item(dlpe_pkg::ACT_ROW, 32'd1, 32'd0, 4'd1, 104'h12);	// zero deltas: 5 + 13
		add_item(dlpe_pkg::ACT_ROW, 32'd9, 32'h10, 4'd0, 104'h0);	// top of the line window
		add_item(dlpe_pkg::ACT_ROW, 32'd3, 32'h11, 4'd0, 104'h0);	// below the window
		add_item(dlpe_pkg::ACT_FINISH, 32'd0, 32'h20, 4'd0, 104'h0);
		add_item(dlpe_pkg::ACT_ROW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 104'h0);	// 13 bytes
		add_item(dlpe_pkg::ACT_ROW, 32'd0, 32'd0, 4'd0, 104'h0);	// offset wraps
		add_item(dlpe_pkg::ACT_ROW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 104'h0);	// 13 bytes
		add_item(dlpe_pkg::ACT_FINISH, 32'hFFFF_FFFF, 32'd0, 4'd0, 104'h0);	// below last
		add_item(dlpe_pkg::ACT_ROW, 32'd0, 32'h80, 4'd0, 104'h0);	// line 0, two-digit offset
		add_item(dlpe_pkg::ACT_ROW, 32'h40, 32'h80, 4'd0, 104'h0);	// +64 needs a sign digit
		add_item(dlpe_pkg::ACT_FINISH, 32'd0, 32'hFFFF_FFFF, 4'd0, 104'h0);
		// widest window, lowest opcode base
		add_write(dlpe_pkg::REG_LBASE, 8'h80);
		add_write(dlpe_pkg::REG_LRANGE, 8'd255);
		add_write(dlpe_pkg::REG_OPCODE_BASE, 8'd1);
		add_item(dlpe_pkg::ACT_ROW, 32'd1, 32'd0, 4'd1, 104'h01);
		add_item(dlpe_pkg::ACT_ROW, 32'd1, 32'd0, 4'd0, 104'h0);
		add_item(dlpe_pkg::ACT_ROW, 32'd127, 32'd0, 4'd1, 104'hFF);	// opcode lands on 255
		add_item(dlpe_pkg::ACT_ROW, 32'd127, 32'd1, 4'd0, 104'h0);	// overflows: long form
		add_item(dlpe_pkg::ACT_FINISH, 32'd0, 32'd1, 4'd5, 104'h02_00_00_01_01);
		// zero range: nothing fits
		add_write(dlpe_pkg::REG_LBASE, 8'h00);
		add_write(dlpe_pkg::REG_LRANGE, 8'd0);
		add_write(dlpe_pkg::REG_OPCODE_BASE, 8'd255);
		add_item(dlpe_pkg::ACT_ROW, 32'd5, 32'd4, 4'd0, 104'h0);
		add_item(dlpe_pkg::ACT_ROW, 32'd5, 32'd4, 4'd0, 104'h0);
		// one-wide window; a write to a missing register must be ignored
		add_write(dlpe_pkg::REG_LRANGE, 8'd1);
		add_write(REG_UNUSED, 8'hAA);
		add_item(dlpe_pkg::ACT_ROW, 32'd5, 32'd4, 4'd1, 104'hFF);
		add_item(dlpe_pkg::ACT_FINISH, 32'd0, 32'd4, 4'd5, 104'h02_00_00_01_01);
		// back to defaults for the first random sequences
		add_write(dlpe_pkg::REG_LBASE, dlpe_pkg::LBASE_RST);
		add_write(dlpe_pkg::REG_LRANGE, dlpe_pkg::LRANGE_RST);
		add_write(dlpe_pkg::REG_OPCODE_BASE, dlpe_pkg::OPCODE_BASE_RST);

		// single reset pulse, released on a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---
		in_cfg = 1'b0;
		for (row_i = 0; row_i < dir_rows.size(); row_i++) begin
			if (dir_rows[row_i].is_cfg) begin
				if (!in_cfg)
					drain_program();	// registers change only while idle
				in_cfg = 1'b1;
				write_reg(dir_rows[row_i].reg_idx, dir_rows[row_i].reg_val);
			end else begin
				if (in_cfg)
					cfg_valid <= 1'b0;
				in_cfg = 1'b0;
				send_item(dir_rows[row_i].act, dir_rows[row_i].line, dir_rows[row_i].offs,
					dir_rows[row_i].n_typed, dir_rows[row_i].typed);
			end
		end
		cfg_valid <= 1'b0;

		// --- random part: mostly well-formed sequences ---
		n_random = 0;
		while (n_random < 195) begin
			// between sequences: sometimes reconfigure, extremes favored
			if ($urandom_range(99) < 30) begin
				drain_program();
				if ($urandom_range(99) < 70) begin
					case ($urandom_range(3))
						0: gen_val = 8'h80;
						1: gen_val = 8'h00;
						2: gen_val = 8'(0 - $urandom_range(128));
						default: gen_val = 8'($urandom);	// positive bases too
					endcase
					write_reg(dlpe_pkg::REG_LBASE, gen_val);
				end
				if ($urandom_range(99) < 70) begin
					case ($urandom_range(4))
						0: gen_val = 8'd1;
						1: gen_val = 8'd255;
						2: gen_val = 8'd0;
						default: gen_val = 8'($urandom);
					endcase
					write_reg(dlpe_pkg::REG_LRANGE, gen_val);
				end
				if ($urandom_range(99) < 70) begin
					case ($urandom_range(3))
						0: gen_val = 8'd1;
						1: gen_val = 8'd255;
						2: gen_val = dlpe_pkg::OPCODE_BASE_RST;
						default: gen_val = 8'($urandom);
					endcase
					write_reg(dlpe_pkg::REG_OPCODE_BASE, gen_val);
				end
				if ($urandom_range(9) == 0)
					write_reg(REG_UNUSED, 8'($urandom));
				cfg_valid <= 1'b0;
			end

			n_rows = ($urandom_range(19) == 0) ? 0 : $urandom_range(12, 1);
			for (row_i = 0; row_i < n_rows; row_i++) begin
				no_idle = (n_random >= 100 && n_random < 150);	// stretch without gaps
				r = $urandom_range(99);
				if (need_first_row) begin
					if (r < 70) begin
						gen_line = $urandom_range(200);
						gen_offs = $urandom_range(64);
					end else begin
						gen_line = $urandom;
						gen_offs = $urandom;
					end
				end else if (r < 70) begin
					// small steps: mostly special opcodes
					gen_line = prog_line + $urandom_range(24) - 8;
					gen_offs = prog_offset + $urandom_range(20);
				end else if (r < 85) begin
					gen_line = prog_line + $urandom_range(4000) - 2000;
					gen_offs = prog_offset + $urandom_range(5000);
				end else begin
					gen_line = $urandom;
					gen_offs = $urandom;
				end
				send_item(dlpe_pkg::ACT_ROW, gen_line, gen_offs, 4'd0, 104'h0);
				n_random++;
				// now and then hold off mid-sequence until the block is empty
				if ($urandom_range(99) < 2)
					drain_program();
			end

			no_idle = (n_random >= 100 && n_random < 150);
			gen_offs = ($urandom_range(9) == 0) ? $urandom : prog_offset + $urandom_range(64);
			send_item(dlpe_pkg::ACT_FINISH, $urandom, gen_offs, 4'd0, 104'h0);
			n_random++;
		end
		no_idle = 1'b0;

		// --- wind down: bounded wait for the last bytes, then settle ---
		in_valid <= 1'b0;
		wait_cnt = 0;
		while (expected_bytes.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (IDLE_PAD) @(negedge clk);
		if (expected_bytes.size() != 0)
			flag_error($sformatf("%0d expected bytes never came", expected_bytes.size()));

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
